// ===== sv/miller_rabin_prime_test_64_assert.svh =====
// Assertion macros used by the checker file mrpt_checker.sv.
`ifndef MILLER_RABIN_PRIME_TEST_64_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_64_ASSERT_SVH

// Clocked property, masked while reset is asserted
`define MRPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked across reset
`define MRPT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mrpt_pkg.sv =====
package mrpt_pkg;

  // Trial divisors and Miller-Rabin bases
  localparam int PRIME_COUNT = 12;
  localparam int PRIME_W     = 6;
  localparam int PRIME_IDX_W = $clog2(PRIME_COUNT);

  localparam logic [PRIME_W-1:0] SMALL_PRIMES [PRIME_COUNT] = '{
    6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
  };

  // Status of the modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_sts_t;

endpackage

// ===== sv/mrpt_modmul.sv =====
module mrpt_modmul #(
  parameter int WORD_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [WORD_WIDTH-1:0]   op_a,
  input  logic [WORD_WIDTH-1:0]   op_b,
  input  logic [WORD_WIDTH-1:0]   modulus,
  output logic [WORD_WIDTH-1:0]   product,
  output mrpt_pkg::mm_sts_t       sts
);
  import mrpt_pkg::*;

  // op_a and op_b must be below modulus; modulus stays put while busy
  logic [WORD_WIDTH-1:0] acc_r, acc_nxt;
  logic [WORD_WIDTH-1:0] a_r, a_nxt;
  logic [WORD_WIDTH-1:0] b_r, b_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  logic [WORD_WIDTH:0]   mod_ext;
  logic [WORD_WIDTH:0]   sum, sum_sub;
  logic [WORD_WIDTH:0]   dbl, dbl_sub;
  logic [WORD_WIDTH-1:0] acc_add, a_dbl;

  // acc + a mod n and 2a mod n, both operands below n
  always_comb begin
    mod_ext = {1'b0, modulus};
    sum     = {1'b0, acc_r} + {1'b0, a_r};
    sum_sub = sum - mod_ext;
    acc_add = (sum >= mod_ext) ? sum_sub[WORD_WIDTH-1:0] : sum[WORD_WIDTH-1:0];
    dbl     = {a_r, 1'b0};
    dbl_sub = dbl - mod_ext;
    a_dbl   = (dbl >= mod_ext) ? dbl_sub[WORD_WIDTH-1:0] : dbl[WORD_WIDTH-1:0];
  end

  // One multiplier bit per cycle, LSB first, stop once the rest is zero
  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = op_a;
      b_nxt    = op_b;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_add;
      end
      a_nxt = a_dbl;
      b_nxt = b_r >> 1;
      if (b_r[WORD_WIDTH-1:1] == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign product  = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ===== sv/miller_rabin_prime_test_64.sv =====
// Trial division by the small primes, then per base about (2*bitlen(d) + s)
// modular products, all on one shared add-and-double unit.
// Throughput: one request at a time; the next is taken as soon as the result
// is in the output register. Reset (rst_n low, synchronous) idles the block.
module miller_rabin_prime_test_64 #(
  parameter int WORD_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_candidate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_prime
);
  import mrpt_pkg::*;

  localparam int CNT_W = $clog2(WORD_WIDTH + 1);
  localparam int S_W   = $clog2(WORD_WIDTH);
  localparam logic [WORD_WIDTH-1:0] ONE_W = WORD_WIDTH'(1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SIEVE = 13'b0000000000010,
    S_CLASS = 13'b0000000000100,
    S_SPLIT = 13'b0000000001000,
    S_BASE  = 13'b0000000010000,
    S_POW   = 13'b0000000100000,
    S_PMUL  = 13'b0000001000000,
    S_PSQS  = 13'b0000010000000,
    S_PSQ   = 13'b0000100000000,
    S_CHECK = 13'b0001000000000,
    S_SQT   = 13'b0010000000000,
    S_SQ    = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [WORD_WIDTH-1:0]  n_r, n_nxt;
  logic [WORD_WIDTH-1:0]  nm1_r, nm1_nxt;
  logic [WORD_WIDTH-1:0]  sh_r, sh_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [PRIME_W-1:0]     rem_r [PRIME_COUNT];
  logic [PRIME_W-1:0]     rem_nxt [PRIME_COUNT];
  logic [PRIME_W-1:0]     rem_step [PRIME_COUNT];
  logic [WORD_WIDTH-1:0]  d_r, d_nxt;
  logic [S_W-1:0]         s_r, s_nxt;
  logic [S_W-1:0]         r_r, r_nxt;
  logic [PRIME_IDX_W-1:0] bi_r, bi_nxt;
  logic [WORD_WIDTH-1:0]  x_r, x_nxt;
  logic [WORD_WIDTH-1:0]  b_r, b_nxt;
  logic [WORD_WIDTH-1:0]  e_r, e_nxt;
  logic                   res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_is_prime_r, out_is_prime_nxt;

  logic                   small_hit, rem_zero, base_pass;
  logic                   mul_start;
  logic [WORD_WIDTH-1:0]  mul_a, mul_b, mul_prod;
  mm_sts_t                mul_sts;

  // Bit-serial remainders by each small prime, MSB first
  always_comb begin
    logic [PRIME_W:0] t;
    small_hit = 1'b0;
    rem_zero  = 1'b0;
    for (int i = 0; i < PRIME_COUNT; i++) begin
      t = {rem_r[i], sh_r[WORD_WIDTH-1]};
      if (t >= {1'b0, SMALL_PRIMES[i]}) begin
        t = t - {1'b0, SMALL_PRIMES[i]};
      end
      rem_step[i] = t[PRIME_W-1:0];
      if (rem_r[i] == '0) begin
        rem_zero = 1'b1;
      end
      if (n_r == {{(WORD_WIDTH-PRIME_W){1'b0}}, SMALL_PRIMES[i]}) begin
        small_hit = 1'b1;
      end
    end
  end

  // Shared modular multiplier
  mrpt_modmul #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .modulus (n_r),
    .product (mul_prod),
    .sts     (mul_sts)
  );

  // Sequencer: sieve, classify, split n-1, then one strong test per base
  always_comb begin
    state_nxt        = state_r;
    n_nxt            = n_r;
    nm1_nxt          = nm1_r;
    sh_nxt           = sh_r;
    cnt_nxt          = cnt_r;
    rem_nxt          = rem_r;
    d_nxt            = d_r;
    s_nxt            = s_r;
    r_nxt            = r_r;
    bi_nxt           = bi_r;
    x_nxt            = x_r;
    b_nxt            = b_r;
    e_nxt            = e_r;
    res_nxt          = res_r;
    out_is_prime_nxt = out_is_prime_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    base_pass        = 1'b0;
    mul_start        = 1'b0;
    mul_a            = x_r;
    mul_b            = x_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt     = in_candidate[WORD_WIDTH-1:0];
          sh_nxt    = in_candidate[WORD_WIDTH-1:0];
          cnt_nxt   = CNT_W'(WORD_WIDTH);
          for (int i = 0; i < PRIME_COUNT; i++) begin
            rem_nxt[i] = '0;
          end
          state_nxt = S_SIEVE;
        end
      end
      S_SIEVE: begin
        sh_nxt  = sh_r << 1;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        nm1_nxt = n_r - ONE_W;
        d_nxt   = n_r - ONE_W;
        s_nxt   = '0;
        bi_nxt  = '0;
        priority if (n_r[WORD_WIDTH-1:1] == '0) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (small_hit) begin
          res_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (rem_zero) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + S_W'(1);
        end else begin
          state_nxt = S_BASE;
        end
      end
      // n > 37 here, so every base is below n and none is skipped
      S_BASE: begin
        x_nxt     = ONE_W;
        b_nxt     = {{(WORD_WIDTH-PRIME_W){1'b0}}, SMALL_PRIMES[bi_r]};
        e_nxt     = d_r;
        state_nxt = S_POW;
      end
      S_POW: begin
        priority if (e_r == '0) begin
          state_nxt = S_CHECK;
        end else if (e_r[0]) begin
          mul_a     = x_r;
          mul_b     = b_r;
          mul_start = !mul_sts.busy;
          state_nxt = S_PMUL;
        end else begin
          state_nxt = S_PSQS;
        end
      end
      S_PMUL: begin
        if (mul_sts.done) begin
          x_nxt     = mul_prod;
          state_nxt = S_PSQS;
        end
      end
      S_PSQS: begin
        e_nxt = e_r >> 1;
        if (e_r[WORD_WIDTH-1:1] == '0) begin
          state_nxt = S_CHECK;
        end else begin
          mul_a     = b_r;
          mul_b     = b_r;
          mul_start = !mul_sts.busy;
          state_nxt = S_PSQ;
        end
      end
      S_PSQ: begin
        if (mul_sts.done) begin
          b_nxt     = mul_prod;
          state_nxt = S_POW;
        end
      end
      S_CHECK: begin
        if (x_r == ONE_W || x_r == nm1_r) begin
          base_pass = 1'b1;
        end else begin
          r_nxt     = S_W'(1);
          state_nxt = S_SQT;
        end
      end
      S_SQT: begin
        if (r_r >= s_r) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          mul_a     = x_r;
          mul_b     = x_r;
          mul_start = !mul_sts.busy;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (mul_sts.done) begin
          x_nxt = mul_prod;
          if (mul_prod == nm1_r) begin
            base_pass = 1'b1;
          end else begin
            r_nxt     = r_r + S_W'(1);
            state_nxt = S_SQT;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = res_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Base survived: move to the next one or declare prime
    if (base_pass) begin
      if (bi_r == PRIME_IDX_W'(PRIME_COUNT - 1)) begin
        res_nxt   = 1'b1;
        state_nxt = S_DONE;
      end else begin
        bi_nxt    = bi_r + PRIME_IDX_W'(1);
        state_nxt = S_BASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r            <= n_nxt;
    nm1_r          <= nm1_nxt;
    sh_r           <= sh_nxt;
    cnt_r          <= cnt_nxt;
    rem_r          <= rem_nxt;
    d_r            <= d_nxt;
    s_r            <= s_nxt;
    r_r            <= r_nxt;
    bi_r           <= bi_nxt;
    x_r            <= x_nxt;
    b_r            <= b_nxt;
    e_r            <= e_nxt;
    res_r          <= res_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

endmodule

// ===== sv/mrpt_checker.sv =====
`include "miller_rabin_prime_test_64_assert.svh"

module mrpt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_prime
);

  // A stalled result holds its value
  `MRPT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_is_prime), "stalled result changed")

  // A request never produces its answer in the next cycle
  `MRPT_ASSERT(a_no_instant, clk, rst_n, in_valid && in_ready && !out_valid |=> !out_valid, "result appeared too early")

  // A new result leaves the block ready for the next request
  `MRPT_ASSERT(a_ready_on_result, clk, rst_n, $rose(out_valid) |-> in_ready, "not ready after result")

  // Reset drops the result channel
  `MRPT_ASSERT_RST(a_reset_clear, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind miller_rabin_prime_test_64 mrpt_checker u_mrpt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_is_prime (out_is_prime)
);
